[sv/clr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clr_pkg: shared types and constants of the continued line reader
// Result and packet types passed between front end, queue and back end,
// plus the character codes the scanner reacts to.
// ----------------------------------------------------------------------------
package clr_pkg;

    // Default counter width and line capacity after reset
    localparam int          COUNT_WIDTH_DEFAULT = 16;
    localparam logic [15:0] CAPACITY_DEFAULT    = 16'd1024;
    localparam logic [15:0] CAPACITY_MIN        = 16'd3;
    localparam logic [15:0] CAPACITY_RESERVE    = 16'd2;

    // Most results one input transfer can cause
    localparam int MAX_RESULTS = 4;
    localparam int NUM_WIDTH   = $clog2(MAX_RESULTS + 1);
    localparam int IDX_WIDTH   = $clog2(MAX_RESULTS);

    // Characters with a special role
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_QUOTED  = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_TRIM    = 3'd3,
        MODE_SKIPLF  = 3'd4
    } mode_t;

    // One result on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       line_end;
        logic       truncated;
        logic       stream_end;
    } result_t;

    // All results of one input transfer, in order from index 0
    typedef struct packed {
        logic [NUM_WIDTH-1:0]         num;
        result_t [MAX_RESULTS-1:0]    res;
    } packet_t;

endpackage
`default_nettype wire

[sv/clr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clr_front: scanner front end
// Classifies each input byte against the scanner mode, updates the line
// state and builds the packet of results the byte causes.
// ----------------------------------------------------------------------------
module clr_front #(
    parameter int COUNT_WIDTH = clr_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              input_done,
    output logic                   push,
    output clr_pkg::packet_t       push_pkt
);
    import clr_pkg::*;

    // Largest limit the counter can reach
    localparam logic [63:0] MAX_LIMIT = (64'd1 << COUNT_WIDTH) - 64'd2;

    mode_t                  mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0] limit_reg, limit_next;

    logic                   do_plain;
    logic                   quoted;
    logic [NUM_WIDTH-1:0]   num;
    result_t [MAX_RESULTS-1:0] res;

    // Turn a capacity into the stored-byte limit of a line
    function automatic logic [COUNT_WIDTH-1:0] limit_of(input logic [15:0] cap);
        logic [15:0] cap_c;
        logic [63:0] lim;
        cap_c = (cap < CAPACITY_MIN) ? CAPACITY_MIN : cap;
        lim   = {48'd0, cap_c - CAPACITY_RESERVE};
        if (lim > MAX_LIMIT) begin
            lim = MAX_LIMIT;
        end
        return lim[COUNT_WIDTH-1:0];
    endfunction

    function automatic result_t mk_byte(input logic [7:0] b);
        result_t r;
        r            = '0;
        r.data       = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic result_t mk_end(input logic tr, input logic se);
        result_t r;
        r            = '0;
        r.line_end   = 1'b1;
        r.truncated  = tr;
        r.stream_end = se;
        return r;
    endfunction

    function automatic result_t mk_stream_end();
        result_t r;
        r            = '0;
        r.stream_end = 1'b1;
        return r;
    endfunction

    // Latch the line limit on a configuration write
    assign limit_next = cfg_we ? limit_of(cfg_wdata) : limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= limit_of(CAPACITY_DEFAULT);
        end else begin
            limit_reg <= limit_next;
        end
    end

    // Classify the byte and build its results
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        num        = '0;
        res        = '0;
        do_plain   = 1'b0;
        quoted     = 1'b0;

        if (input_done) begin
            res[0]     = (count_reg != '0) ? mk_end(1'b0, 1'b1) : mk_stream_end();
            num        = NUM_WIDTH'(1);
            mode_next  = MODE_NORMAL;
            count_next = '0;
            pend_next  = 1'b0;
        end else begin
            unique case (mode_reg)
                MODE_QUOTED: begin
                    do_plain = 1'b1;
                    quoted   = 1'b1;
                end
                MODE_COMMENT: begin
                    if (in_byte == CHAR_LF) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_TRIM: begin
                    if (in_byte != CHAR_SPACE && in_byte != CHAR_TAB) begin
                        do_plain = 1'b1;
                    end
                end
                MODE_SKIPLF: begin
                    if (in_byte == CHAR_LF) begin
                        mode_next = MODE_NORMAL;
                    end else begin
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase
        end

        if (do_plain) begin
            mode_next = MODE_NORMAL;
            if (in_byte == CHAR_BSLASH && !quoted) begin
                mode_next = MODE_QUOTED;
            end else if (in_byte == CHAR_HASH) begin
                // flush a held newline
                if (pend_next) begin
                    res[num[IDX_WIDTH-1:0]] = mk_byte(CHAR_LF);
                    num       = num + NUM_WIDTH'(1);
                    pend_next = 1'b0;
                end
                if (quoted) begin
                    res[num[IDX_WIDTH-1:0]] = mk_byte(in_byte);
                    num        = num + NUM_WIDTH'(1);
                    count_next = count_next + COUNT_WIDTH'(1);
                    if (count_next >= limit_reg) begin
                        res[num[IDX_WIDTH-1:0]] = mk_end(1'b1, 1'b0);
                        num        = num + NUM_WIDTH'(1);
                        count_next = '0;
                        pend_next  = 1'b0;
                    end
                end else begin
                    res[num[IDX_WIDTH-1:0]] = mk_end(1'b0, 1'b0);
                    num        = num + NUM_WIDTH'(1);
                    count_next = '0;
                    pend_next  = 1'b0;
                    mode_next  = MODE_COMMENT;
                end
            end else if (in_byte == CHAR_LF) begin
                if (quoted) begin
                    mode_next = MODE_TRIM;
                end else begin
                    if (pend_next) begin
                        res[num[IDX_WIDTH-1:0]] = mk_byte(CHAR_LF);
                        num = num + NUM_WIDTH'(1);
                    end
                    res[num[IDX_WIDTH-1:0]] = mk_end(1'b0, 1'b0);
                    num        = num + NUM_WIDTH'(1);
                    count_next = '0;
                    pend_next  = 1'b0;
                end
            end else if (in_byte == CHAR_CR) begin
                if (pend_next) begin
                    res[num[IDX_WIDTH-1:0]] = mk_byte(CHAR_LF);
                    num       = num + NUM_WIDTH'(1);
                    pend_next = 1'b0;
                end
                mode_next = MODE_SKIPLF;
                if (quoted) begin
                    // hold a newline, counted but not yet sent
                    pend_next  = 1'b1;
                    count_next = count_next + COUNT_WIDTH'(1);
                    if (count_next >= limit_reg) begin
                        res[num[IDX_WIDTH-1:0]] = mk_end(1'b1, 1'b0);
                        num        = num + NUM_WIDTH'(1);
                        count_next = '0;
                        pend_next  = 1'b0;
                    end
                end else begin
                    res[num[IDX_WIDTH-1:0]] = mk_end(1'b0, 1'b0);
                    num        = num + NUM_WIDTH'(1);
                    count_next = '0;
                    pend_next  = 1'b0;
                end
            end else begin
                if (pend_next) begin
                    res[num[IDX_WIDTH-1:0]] = mk_byte(CHAR_LF);
                    num       = num + NUM_WIDTH'(1);
                    pend_next = 1'b0;
                end
                // keep the backslash of an ordinary escaped byte
                if (quoted) begin
                    res[num[IDX_WIDTH-1:0]] = mk_byte(CHAR_BSLASH);
                    num        = num + NUM_WIDTH'(1);
                    count_next = count_next + COUNT_WIDTH'(1);
                end
                res[num[IDX_WIDTH-1:0]] = mk_byte(in_byte);
                num        = num + NUM_WIDTH'(1);
                count_next = count_next + COUNT_WIDTH'(1);
                if (count_next >= limit_reg) begin
                    res[num[IDX_WIDTH-1:0]] = mk_end(1'b1, 1'b0);
                    num        = num + NUM_WIDTH'(1);
                    count_next = '0;
                    pend_next  = 1'b0;
                end
            end
        end
    end

    // Hand non-empty packets to the queue
    assign push         = in_accept && (num != '0);
    assign push_pkt.num = num;
    assign push_pkt.res = res;

    // Advance the line state on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

endmodule
`default_nettype wire

[sv/clr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clr_queue: two-entry packet queue
// Decouples the front end from the back end so each side stalls alone.
// ----------------------------------------------------------------------------
module clr_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire clr_pkg::packet_t  push_pkt,
    input  wire logic              pop,
    output clr_pkg::packet_t       pop_pkt,
    output logic                   full,
    output logic                   not_empty
);
    import clr_pkg::*;

    packet_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_pkt   = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store a pushed packet
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule
`default_nettype wire

[sv/clr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clr_back: result sequencer
// Holds one packet and sends its results one transfer at a time, marking
// the final one of each packet.
// ----------------------------------------------------------------------------
module clr_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_not_empty,
    input  wire clr_pkg::packet_t  q_pkt,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_byte_valid,
    output logic                   m_line_end,
    output logic                   m_truncated,
    output logic                   m_stream_end,
    output logic                   m_last
);
    import clr_pkg::*;

    packet_t              cur_reg;
    logic                 valid_reg;
    logic [IDX_WIDTH-1:0] idx_reg;
    logic                 at_last;
    logic                 advance;
    logic                 load;
    result_t              cur_res;

    assign at_last = ({1'b0, idx_reg} + NUM_WIDTH'(1)) == cur_reg.num;
    assign advance = valid_reg && m_ready;
    assign load    = (!valid_reg || (advance && at_last)) && q_not_empty;
    assign q_pop   = load;

    // Step through the held packet
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (advance) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + IDX_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= q_pkt;
        end
    end

    // Drive the current result
    assign cur_res      = cur_reg.res[idx_reg];
    assign m_valid      = valid_reg;
    assign m_out_byte   = cur_res.data;
    assign m_byte_valid = cur_res.byte_valid;
    assign m_line_end   = cur_res.line_end;
    assign m_truncated  = cur_res.truncated;
    assign m_stream_end = cur_res.stream_end;
    assign m_last       = at_last;

endmodule
`default_nettype wire

[sv/continued_line_reader_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// continued_line_reader_core: logical line splitter for a byte stream
// Joins backslash-continued lines, strips comments and emits content bytes
// and line ends as separate results.
// ----------------------------------------------------------------------------
// The core takes one byte (or an end-of-input mark) per transfer and sends
// each content byte and each line end as a result of its own; the final
// result of an input transfer carries m_last. Bytes that cause no result or
// one result stream at one byte per clock while the queue has room. A byte
// that causes several results (at most four) holds the output port while the
// back end sends them one result per cycle whenever m_ready is high; a
// two-entry queue between scanner and output absorbs this, and the input
// stalls only once that queue is full. Results pass through a queue entry and
// the back end's held packet register before they appear. Write cfg_wdata
// (line capacity) only while the core is idle; lines end truncated once capacity minus two bytes are held.
// ----------------------------------------------------------------------------
module continued_line_reader_core #(
    parameter int COUNT_WIDTH = clr_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_input_done,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_line_end,
    output logic             m_truncated,
    output logic             m_stream_end,
    output logic             m_last
);
    import clr_pkg::*;

    logic    in_accept;
    logic    push;
    packet_t push_pkt;
    logic    q_pop;
    packet_t q_pkt;
    logic    q_full;
    logic    q_not_empty;

    // Accept input while the queue has room
    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    clr_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (in_accept),
        .in_byte    (s_in_byte),
        .input_done (s_input_done),
        .push       (push),
        .push_pkt   (push_pkt)
    );

    clr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_pkt  (push_pkt),
        .pop       (q_pop),
        .pop_pkt   (q_pkt),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    clr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_pkt        (q_pkt),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_line_end   (m_line_end),
        .m_truncated  (m_truncated),
        .m_stream_end (m_stream_end),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire

[sv/clr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clr_checker: port-level checks of the continued line reader
// Watches the result channel for stalled data and impossible result kinds.
// ----------------------------------------------------------------------------
module clr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_byte_valid,
    input wire logic       m_line_end,
    input wire logic       m_truncated,
    input wire logic       m_stream_end,
    input wire logic       m_last
);

    // Hold a stalled result
    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_line_end) && $stable(m_last);
    endproperty
    a_hold: assert property (p_hold) else $error("stalled result changed");

    // A result is content or a line end, never both
    property p_kind;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_byte_valid && m_line_end);
    endproperty
    a_kind: assert property (p_kind) else $error("byte and line end together");

    // Truncation only on a line end that does not end the stream
    property p_trunc;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_line_end && !m_stream_end;
    endproperty
    a_trunc: assert property (p_trunc) else $error("bad truncation flag");

    // End of stream is the final result of its transfer and carries no byte
    property p_stream;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> m_last && !m_byte_valid;
    endproperty
    a_stream: assert property (p_stream) else $error("bad stream end");

    // Content bytes are zero-free only through byte_valid: idle fields stay zero
    property p_zero;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_out_byte == 8'd0;
    endproperty
    a_zero: assert property (p_zero) else $error("data on a non-byte result");

endmodule

bind continued_line_reader_core clr_checker u_clr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_byte_valid (m_byte_valid),
    .m_line_end   (m_line_end),
    .m_truncated  (m_truncated),
    .m_stream_end (m_stream_end),
    .m_last       (m_last)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for continued_line_reader_core
// Feeds directed and random text streams through the core under several line
// capacities, predicts every content byte and line end from a behavioral
// scanner kept in step with each input transfer, and checks every output
// transfer in order. Both sides idle at random; the receiver also holds off
// once for a long stretch so that the core backs up into its input.
// ----------------------------------------------------------------------------
module tb;
    import clr_pkg::*;

    // One input item and one predicted result
    typedef struct packed {
        logic [7:0] ch;
        logic       done;
    } text_item_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } line_result_t;

    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [15:0] cfg_wdata    = 16'd0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte    = 8'd0;
    logic        s_input_done = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_line_end;
    logic        m_truncated;
    logic        m_stream_end;
    logic        m_last;

    continued_line_reader_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_input_done(s_input_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_byte_valid(m_byte_valid),
        .m_line_end  (m_line_end),
        .m_truncated (m_truncated),
        .m_stream_end(m_stream_end),
        .m_last      (m_last)
    );

    // Clock: 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and scoreboard storage
    text_item_t   text_feed[$];
    line_result_t line_results_due[$];
    line_result_t step_results[$];

    logic item_in_flight = 1'b0;
    logic idle_on        = 1'b1;
    logic stall_armed    = 1'b0;
    logic stall_done     = 1'b0;
    int   hold_left      = 0;
    int   errors         = 0;
    int   items_taken    = 0;
    int   results_seen   = 0;

    // Scanner state mirrored for prediction
    logic [15:0] pred_cap   = CAPACITY_DEFAULT;
    mode_t       pred_mode  = MODE_NORMAL;
    logic [15:0] pred_count = 16'd0;
    logic        pred_nl    = 1'b0;

    // ------------------------------------------------------------------------
    // Line scanner prediction
    // ------------------------------------------------------------------------
    function automatic void emit(logic [7:0] d, logic bv, logic le, logic tr, logic se);
        line_result_t r;
        r.res.data       = d;
        r.res.byte_valid = bv;
        r.res.line_end   = le;
        r.res.truncated  = tr;
        r.res.stream_end = se;
        r.last           = 1'b0;
        step_results.push_back(r);
    endfunction

    // Emit a held newline ahead of the next byte or line end
    function automatic void flush_newline();
        if (pred_nl) begin
            emit(CHAR_LF, 1'b1, 1'b0, 1'b0, 1'b0);
            pred_nl = 1'b0;
        end
    endfunction

    function automatic void keep_byte(logic [7:0] d);
        emit(d, 1'b1, 1'b0, 1'b0, 1'b0);
        pred_count = pred_count + 16'd1;
    endfunction

    function automatic void close_line(logic tr);
        emit(8'd0, 1'b0, 1'b1, tr, 1'b0);
        pred_count = 16'd0;
        pred_nl    = 1'b0;
    endfunction

    // End the line as truncated once the stored count hits capacity minus two
    function automatic void check_limit();
        logic [15:0] lim;
        lim = (pred_cap < CAPACITY_MIN) ? 16'd1 : pred_cap - CAPACITY_RESERVE;
        if (pred_count >= lim)
            close_line(1'b1);
    endfunction

    function automatic void scan_plain(logic [7:0] c, logic quoted);
        pred_mode = MODE_NORMAL;
        if (c == CHAR_BSLASH && !quoted) begin
            pred_mode = MODE_QUOTED;
        end else if (c == CHAR_HASH) begin
            flush_newline();
            if (quoted) begin
                keep_byte(c);
                check_limit();
            end else begin
                close_line(1'b0);
                pred_mode = MODE_COMMENT;
            end
        end else if (c == CHAR_LF) begin
            if (quoted) begin
                pred_mode = MODE_TRIM;
            end else begin
                flush_newline();
                close_line(1'b0);
            end
        end else if (c == CHAR_CR) begin
            flush_newline();
            pred_mode = MODE_SKIPLF;
            if (quoted) begin
                // Escaped CR holds a newline that counts toward the limit
                pred_nl    = 1'b1;
                pred_count = pred_count + 16'd1;
                check_limit();
            end else begin
                close_line(1'b0);
            end
        end else begin
            flush_newline();
            if (quoted)
                keep_byte(CHAR_BSLASH);
            keep_byte(c);
            check_limit();
        end
    endfunction

    // Predict all results of one accepted input transfer
    function automatic void scan_item(logic [7:0] c, logic done);
        step_results.delete();
        if (done) begin
            if (pred_count != 16'd0)
                emit(8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
            else
                emit(8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
            pred_mode  = MODE_NORMAL;
            pred_count = 16'd0;
            pred_nl    = 1'b0;
        end else begin
            case (pred_mode)
                MODE_QUOTED: begin
                    scan_plain(c, 1'b1);
                end
                MODE_COMMENT: begin
                    if (c == CHAR_LF)
                        pred_mode = MODE_NORMAL;
                end
                MODE_TRIM: begin
                    if (c != CHAR_SPACE && c != CHAR_TAB)
                        scan_plain(c, 1'b0);
                end
                MODE_SKIPLF: begin
                    if (c == CHAR_LF)
                        pred_mode = MODE_NORMAL;
                    else
                        scan_plain(c, 1'b0);
                end
                default: begin
                    scan_plain(c, 1'b0);
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            line_results_due.push_back(step_results[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: present queued items, hold each until its transfer
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_text
        text_item_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_item(s_in_byte, s_input_done);
                item_in_flight = 1'b0;
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (text_feed.size() > 0 && !(idle_on && $urandom_range(99) < 15)) begin
                    next_item = text_feed.pop_front();
                    s_in_byte    <= next_item.ch;
                    s_input_done <= next_item.done;
                    s_valid      <= 1'b1;
                    item_in_flight = 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random idling plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_armed && !stall_done) begin
            m_ready    <= 1'b0;
            hold_left  <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 15);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : check_results
        line_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (line_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none got byte %h bv %b le %b",
                         $time, m_out_byte, m_byte_valid, m_line_end);
            end else begin
                want = line_results_due.pop_front();
                check_field("out_byte",   want.res.data,           m_out_byte);
                check_field("byte_valid", 8'(want.res.byte_valid), 8'(m_byte_valid));
                check_field("line_end",   8'(want.res.line_end),   8'(m_line_end));
                check_field("truncated",  8'(want.res.truncated),  8'(m_truncated));
                check_field("stream_end", 8'(want.res.stream_end), 8'(m_stream_end));
                check_field("last",       8'(want.last),           8'(m_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_char(logic [7:0] c);
        text_item_t it;
        it.ch   = c;
        it.done = 1'b0;
        text_feed.push_back(it);
    endfunction

    function automatic void push_end(logic [7:0] c);
        text_item_t it;
        it.ch   = c;
        it.done = 1'b1;
        text_feed.push_back(it);
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    // Mostly well-formed text: words, line ends, comments, continuations
    task automatic gen_text(int n);
        int start;
        int k;
        start = text_feed.size();
        while (text_feed.size() - start < n) begin
            k = $urandom_range(99);
            if (k < 45) begin
                push_char(8'($urandom_range(8'h21, 8'h7E)));
            end else if (k < 53) begin
                push_char(blank_char());
            end else if (k < 61) begin
                push_char(CHAR_LF);
            end else if (k < 65) begin
                push_char(CHAR_CR);
            end else if (k < 70) begin
                push_char(CHAR_CR);
                push_char(CHAR_LF);
            end else if (k < 75) begin
                push_char(CHAR_HASH);
                repeat ($urandom_range(3)) push_char(8'($urandom_range(255)));
                push_char(CHAR_LF);
            end else if (k < 86) begin
                push_char(CHAR_BSLASH);
                case ($urandom_range(5))
                    0: begin
                        push_char(CHAR_LF);
                        repeat ($urandom_range(3)) push_char(blank_char());
                    end
                    1: push_char(CHAR_CR);
                    2: begin
                        push_char(CHAR_CR);
                        push_char(CHAR_LF);
                    end
                    3: push_char(CHAR_HASH);
                    4: push_char(CHAR_BSLASH);
                    default: push_char(8'($urandom_range(255)));
                endcase
            end else if (k < 96) begin
                push_char(8'($urandom_range(255)));
            end else begin
                push_end(8'($urandom_range(255)));
            end
        end
    endtask

    // Wait until every item is in and every result is out, then drain
    task automatic settle();
        while (text_feed.size() > 0 || item_in_flight || line_results_due.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [15:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        pred_cap  = cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default capacity: field extremes and every escape and line end form
        push_char("a");
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CHAR_LF);
        push_char(CHAR_BSLASH);
        push_char(CHAR_LF);
        push_char(CHAR_SPACE);
        push_char(CHAR_TAB);
        push_char("c");
        push_char(CHAR_CR);
        push_char(CHAR_LF);
        // Escaped CRLF holds a newline that a comment start then flushes
        push_char(CHAR_BSLASH);
        push_char(CHAR_CR);
        push_char(CHAR_LF);
        push_char(CHAR_HASH);
        push_char("x");
        push_char(CHAR_LF);
        // Escaped hash and escaped ordinary byte
        push_char(CHAR_BSLASH);
        push_char(CHAR_HASH);
        push_char(CHAR_BSLASH);
        push_char("z");
        // Held newline dropped at end of input, then an empty end of input
        push_char(CHAR_BSLASH);
        push_char(CHAR_CR);
        push_end(8'hFF);
        push_end(8'h00);
        gen_text(30);
        settle();

        // Smallest capacity: every stored byte ends the line
        write_capacity(CAPACITY_MIN);
        push_char("a");
        push_char(CHAR_BSLASH);
        push_char("b");
        push_char(CHAR_BSLASH);
        push_char(CHAR_CR);
        push_char("q");
        gen_text(30);
        settle();

        // Largest capacity with a long output hold-off
        write_capacity(16'hFFFF);
        stall_armed <= 1'b1;
        gen_text(30);
        settle();

        // Small capacity, no idling on either side
        write_capacity(16'd5);
        idle_on <= 1'b0;
        gen_text(30);
        settle();

        // Random small capacity, idling back on
        write_capacity(16'($urandom_range(4, 40)));
        idle_on <= 1'b1;
        gen_text(30);
        settle();

        // Back to the default capacity
        write_capacity(CAPACITY_DEFAULT);
        gen_text(20);
        settle();

        if (line_results_due.size() > 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     line_results_due.size());
        end
        $display("Run covered %0d input transfers and %0d result transfers", items_taken,
                 results_seen);
        $display("over capacities 3 to 65535 with random idling and one long output stall");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Timeout guard
    initial begin
        #500_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
